// ===== src/cct_pkg.sv =====
`timescale 1ns / 1ps
// Package for the client connection match table: sizes, operation and status
// codes, item structs and the controller/datapath command and status structs.
// Depends on nothing.
package cct_pkg;

  localparam int MAX_CLIENTS = 64;
  localparam int ADDR_WIDTH  = 48;
  localparam int SLOT_W      = (MAX_CLIENTS > 1) ? $clog2(MAX_CLIENTS) : 1;
  localparam int CNT_W       = $clog2(MAX_CLIENTS + 1);

  localparam logic [6:0] ACTIVE_RESET = 7'd64;

  localparam logic [2:0] OP_ADD              = 3'd0;
  localparam logic [2:0] OP_REMOVE           = 3'd1;
  localparam logic [2:0] OP_FIND_ADDR        = 3'd2;
  localparam logic [2:0] OP_FIND_ADDR_CLIENT = 3'd3;
  localparam logic [2:0] OP_FIND_ALL         = 3'd4;
  localparam logic [2:0] OP_EXISTS           = 3'd5;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_RANGE     = 2'd2;

  typedef struct packed {
    logic [2:0]  op;
    logic [5:0]  entry_index;
    logic [47:0] address_key;
    logic [15:0] client_id;
    logic [15:0] server_id;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [5:0] match_index;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_WIDTH-1:0] address;
    logic [15:0]           client_id;
    logic [15:0]           server_id;
  } slot_word_t;

  typedef struct packed {
    logic capture;
    logic update;
    logic scan_start;
    logic scan_step;
    logic emit;
  } cct_cmd_t;

  typedef struct packed {
    logic is_find;
    logic scan_hit;
    logic scan_end;
    logic out_free;
  } cct_stat_t;

endpackage

// ===== src/cct_datapath.sv =====
`timescale 1ns / 1ps
// Datapath of the match table: request register, slot memory, valid marks,
// active client register with its slot count clamp, scan counter, comparators and output register.
// Depends on cct_pkg.
module cct_datapath import cct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  cct_cmd_t  cmd,
  output cct_stat_t stat,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item,
  input  logic      cfg_valid,
  input  logic [6:0] cfg_data
);

  in_item_t             req;
  logic [6:0]           active_clients;
  logic [CNT_W-1:0]     slot_count;
  logic [MAX_CLIENTS-1:0] slot_valid;
  slot_word_t           mem [MAX_CLIENTS];
  slot_word_t           rd_data;
  logic                 rd_vbit;
  logic [CNT_W-1:0]     rd_idx;
  logic                 cmp_valid;
  logic [SLOT_W-1:0]    cmp_idx;
  logic                 rd_en;
  logic                 mem_we;
  logic                 in_range;
  logic                 hit;
  out_item_t            res;

  assign slot_count = (active_clients > MAX_CLIENTS) ? CNT_W'(MAX_CLIENTS)
                                                     : CNT_W'(active_clients);
  assign in_range   = 32'(req.entry_index) < 32'(slot_count);
  assign mem_we     = cmd.update && (req.op == OP_ADD) && in_range;
  assign rd_en      = cmd.scan_step && !stat.scan_hit && (rd_idx < slot_count);

  always_comb begin
    hit = cmp_valid && rd_vbit;
    if (req.op != OP_EXISTS) begin
      hit = hit && (rd_data.address == ADDR_WIDTH'(req.address_key));
    end
    if (req.op != OP_FIND_ADDR) begin
      hit = hit && (rd_data.client_id == req.client_id);
    end
    if ((req.op == OP_FIND_ALL) || (req.op == OP_EXISTS)) begin
      hit = hit && (rd_data.server_id == req.server_id);
    end
  end

  assign stat.is_find  = req.op inside {[OP_FIND_ADDR:OP_EXISTS]};
  assign stat.scan_hit = hit;
  assign stat.scan_end = hit || (!cmp_valid && (rd_idx >= slot_count));
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[SLOT_W'(req.entry_index)] <= '{address:   ADDR_WIDTH'(req.address_key),
                                         client_id: req.client_id,
                                         server_id: req.server_id};
    end
    if (rd_en) begin
      rd_data <= mem[rd_idx[SLOT_W-1:0]];
      rd_vbit <= slot_valid[rd_idx[SLOT_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req <= in_item;
    end
    if (cmd.scan_start) begin
      cmp_idx <= '0;
    end else if (rd_en) begin
      cmp_idx <= rd_idx[SLOT_W-1:0];
    end
    if (cmd.update) begin
      if ((req.op == OP_ADD) || (req.op == OP_REMOVE)) begin
        res.status <= in_range ? ST_OK : ST_RANGE;
      end else begin
        res.status <= ST_NOT_FOUND;
      end
      res.match_index <= '0;
    end else if (cmd.scan_step && stat.scan_end) begin
      res.status      <= hit ? ST_OK : ST_NOT_FOUND;
      res.match_index <= hit ? 6'(cmp_idx) : 6'd0;
    end
    if (cmd.emit) begin
      out_item <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_clients <= ACTIVE_RESET;
      slot_valid     <= '0;
      rd_idx         <= '0;
      cmp_valid      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid) begin
        active_clients <= cfg_data;
      end
      if (cmd.update && in_range) begin
        if (req.op == OP_ADD) begin
          slot_valid[SLOT_W'(req.entry_index)] <= 1'b1;
        end else if (req.op == OP_REMOVE) begin
          slot_valid[SLOT_W'(req.entry_index)] <= 1'b0;
        end
      end
      if (cmd.scan_start) begin
        rd_idx    <= '0;
        cmp_valid <= 1'b0;
      end else if (cmd.scan_step) begin
        cmp_valid <= rd_en;
        if (rd_en) begin
          rd_idx <= rd_idx + CNT_W'(1);
        end
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== src/cct_controller.sv =====
`timescale 1ns / 1ps
// Controller of the match table: sequences capture, update or scan, and
// hand-off of the result to the output register. Depends on cct_pkg.
module cct_controller import cct_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  cct_stat_t stat,
  output cct_cmd_t  cmd
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_SCAN   = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DECODE;
        end
      end
      S_DECODE: begin
        if (stat.is_find) begin
          cmd.scan_start = 1'b1;
          state_next     = S_SCAN;
        end else begin
          cmd.update = 1'b1;
          state_next = S_FINISH;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (stat.scan_end) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat.out_free) begin
          cmd.emit   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== src/client_connection_match_table.sv =====
`timescale 1ns / 1ps
// Client connection match table, top level. Add, remove and unused op codes give a
// result without a scan; a find or exists scans slots from 0 upward and reports the
// first hit, or a miss after slot n-1 (at once if n is zero), n being active_clients
// clamped to 64, one slot per cycle. A new item is taken only after the last result.
// A result held back by out_ready delays the next one. Reset clears all valid marks at
// once and sets active_clients to 64. Depends on cct_pkg, cct_controller and cct_datapath.
module client_connection_match_table import cct_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_item_t   in_item,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [6:0] cfg_data
);

  cct_cmd_t  cmd;
  cct_stat_t stat;

  assign cfg_ready = 1'b1;

  cct_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  cct_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data)
  );

endmodule

// ===== src/cct_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the match table and the bind that attaches them.
// Depends on cct_pkg and client_connection_match_table.
module cct_checker import cct_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input out_item_t  out_item
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_item))
    else $error("result changed or dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("new item taken while one is in work");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.status == ST_OK) || (out_item.status == ST_NOT_FOUND) ||
                  (out_item.status == ST_RANGE))
    else $error("unknown status code");

  a_index_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.status != ST_OK) |-> out_item.match_index == 6'd0)
    else $error("nonzero index on a failed item");

endmodule

bind client_connection_match_table cct_checker u_chk (.*);

// ===== tb/sv/client_connection_match_table_tb.sv =====
`timescale 1ns / 1ps
// Testbench for client_connection_match_table: directed and random add, remove, find and
// exists items under several slot counts and idling patterns, checked by a table model.
// Depends on cct_pkg and the client_connection_match_table RTL.
module client_connection_match_table_tb;
  import cct_pkg::*;

  localparam logic [2:0] OP_SPARE_A = 3'd6;
  localparam logic [2:0] OP_SPARE_B = 3'd7;
  localparam logic [47:0] ADDR_ONES = 48'hFFFF_FFFF_FFFF;
  localparam logic [47:0] ADDR_MIX = 48'h1234_5678_9ABC;
  localparam int TIMEOUT_CYCLES = 1000000;
  localparam int HOLD_CYCLES = 600;
  localparam int PHASE_ITEMS = 104;
  localparam int NUM_PHASES = 8;
  localparam int TAIL_CYCLES = 80;
  localparam int MAX_PRINTED = 100;

  class conn_table_checker;
    logic [6:0]  active;
    bit          slot_used [MAX_CLIENTS];
    logic [47:0] slot_addr [MAX_CLIENTS];
    logic [15:0] slot_cid [MAX_CLIENTS];
    logic [15:0] slot_sid [MAX_CLIENTS];
    out_item_t   lookup_results [$];
    int          errors;

    function new();
      active = ACTIVE_RESET;
      errors = 0;
      foreach (slot_used[i]) slot_used[i] = 1'b0;
    endfunction

    function int unsigned slot_limit();
      return (active > MAX_CLIENTS) ? MAX_CLIENTS : active;
    endfunction

    function void note_item(in_item_t it);
      out_item_t   res;
      int unsigned n;
      bit          hit;
      bit          found;
      n = slot_limit();
      res.status = ST_NOT_FOUND;
      res.match_index = '0;
      found = 1'b0;
      case (it.op)
        OP_ADD, OP_REMOVE: begin
          if (it.entry_index >= n) begin
            res.status = ST_RANGE;
          end else begin
            res.status = ST_OK;
            slot_used[it.entry_index] = (it.op == OP_ADD);
            if (it.op == OP_ADD) begin
              slot_addr[it.entry_index] = it.address_key;
              slot_cid[it.entry_index] = it.client_id;
              slot_sid[it.entry_index] = it.server_id;
            end
          end
        end
        OP_FIND_ADDR, OP_FIND_ADDR_CLIENT, OP_FIND_ALL, OP_EXISTS: begin
          for (int i = 0; i < n; i++) begin
            hit = slot_used[i];
            if (hit && it.op != OP_EXISTS && slot_addr[i] != it.address_key) hit = 1'b0;
            if (hit && it.op != OP_FIND_ADDR && slot_cid[i] != it.client_id) hit = 1'b0;
            if (hit && (it.op == OP_FIND_ALL || it.op == OP_EXISTS) &&
                slot_sid[i] != it.server_id) hit = 1'b0;
            if (hit && !found) begin
              found = 1'b1;
              res.status = ST_OK;
              res.match_index = 6'(i);
            end
          end
        end
        default: ;
      endcase
      lookup_results.push_back(res);
    endfunction

    task report_mismatch(string what);
      errors++;
      if (errors <= MAX_PRINTED) $display("%0t ERROR: %s", $time, what);
    endtask

    task check_result(out_item_t got);
      out_item_t want;
      if (lookup_results.size() == 0) begin
        report_mismatch($sformatf("result status %0d index %0d with no item waiting",
                                  got.status, got.match_index));
        return;
      end
      want = lookup_results.pop_front();
      if (got.status !== want.status)
        report_mismatch($sformatf("status %0d, expected %0d", got.status, want.status));
      if (got.match_index !== want.match_index)
        report_mismatch($sformatf("match_index %0d, expected %0d",
                                  got.match_index, want.match_index));
    endtask
  endclass

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  in_item_t   in_item = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_item;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [6:0] cfg_data = ACTIVE_RESET;

  logic       holding = 1'b0;
  int         send_idle_pct = 0;
  int         stall_pct = 0;
  int         cycle_count = 0;
  event       hold_go;

  logic [47:0] addr_pool [4] = '{48'h0, ADDR_ONES, 48'hC0A8_0001_1F90, 48'h0A00_0002_0050};
  logic [15:0] id_pool [4] = '{16'h0000, 16'hFFFF, 16'h0001, 16'h8000};
  int          phase_active [NUM_PHASES] = '{64, 17, 1, 64, 40, 127, 8, 64};
  int          phase_idle [NUM_PHASES] = '{0, 84, 0, 9, 0, 84, 0, 9};
  int          phase_stall [NUM_PHASES] = '{0, 0, 84, 9, 0, 0, 84, 9};

  conn_table_checker sb = new();

  client_connection_match_table dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    out_ready <= !holding && ($urandom_range(99) >= stall_pct);
  end

  initial begin
    forever begin
      @(hold_go);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      holding <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.active = cfg_data;
      if (in_valid && in_ready) sb.note_item(in_item);
      if (out_valid && out_ready) sb.check_result(out_item);
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= TIMEOUT_CYCLES) begin
      $display("client_connection_match_table: mismatch");
      $finish;
    end
  end

  function automatic in_item_t make_item(logic [2:0] op, logic [5:0] idx, logic [47:0] addr,
                                         logic [15:0] cid, logic [15:0] sid);
    in_item_t it;
    it.op = op;
    it.entry_index = idx;
    it.address_key = addr;
    it.client_id = cid;
    it.server_id = sid;
    return it;
  endfunction

  // Finds, in three of four tries, reuse the contents of a random slot if it is live,
  // sometimes with one bit changed, so that hits, near misses and duplicate keys all occur.
  function automatic in_item_t random_item();
    in_item_t    it;
    int unsigned n;
    int unsigned roll;
    int unsigned s;
    n = sb.slot_limit();
    roll = $urandom_range(99);
    it.address_key = ($urandom_range(3) == 0) ? 48'({$urandom, $urandom})
                                              : addr_pool[$urandom_range(3)];
    it.client_id = ($urandom_range(3) == 0) ? 16'($urandom) : id_pool[$urandom_range(3)];
    it.server_id = ($urandom_range(3) == 0) ? 16'($urandom) : id_pool[$urandom_range(3)];
    it.entry_index = (n != 0 && $urandom_range(9) != 0) ? 6'($urandom_range(n - 1))
                                                        : 6'($urandom_range(63));
    if (roll < 30) begin
      it.op = OP_ADD;
    end else if (roll < 42) begin
      it.op = OP_REMOVE;
    end else if (roll < 97) begin
      case ($urandom_range(3))
        0: it.op = OP_FIND_ADDR;
        1: it.op = OP_FIND_ADDR_CLIENT;
        2: it.op = OP_FIND_ALL;
        default: it.op = OP_EXISTS;
      endcase
      s = $urandom_range(MAX_CLIENTS - 1);
      if ($urandom_range(3) != 0 && sb.slot_used[s]) begin
        it.address_key = sb.slot_addr[s];
        it.client_id = sb.slot_cid[s];
        it.server_id = sb.slot_sid[s];
        case ($urandom_range(7))
          0: it.address_key = it.address_key ^ (48'd1 << $urandom_range(47));
          1: it.client_id = it.client_id ^ (16'd1 << $urandom_range(15));
          2: it.server_id = it.server_id ^ (16'd1 << $urandom_range(15));
          default: ;
        endcase
      end
    end else begin
      it.op = ($urandom_range(1) == 0) ? OP_SPARE_A : OP_SPARE_B;
    end
    return it;
  endfunction

  task automatic send_item(in_item_t it);
    in_item <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.lookup_results.size() != 0);
  endtask

  task automatic set_active(logic [6:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int p;
    int k;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    set_active(7'd64);
    send_item(make_item(OP_FIND_ADDR, 6'd0, ADDR_ONES, 16'h0, 16'h0));
    send_item(make_item(OP_ADD, 6'd0, ADDR_ONES, 16'hFFFF, 16'hFFFF));
    send_item(make_item(OP_ADD, 6'd63, 48'h0, 16'h0, 16'h0));
    send_item(make_item(OP_ADD, 6'd5, ADDR_ONES, 16'h1234, 16'hABCD));
    send_item(make_item(OP_FIND_ADDR, 6'd0, ADDR_ONES, 16'h0, 16'h0));
    send_item(make_item(OP_FIND_ADDR_CLIENT, 6'd0, ADDR_ONES, 16'h1234, 16'h0));
    send_item(make_item(OP_FIND_ALL, 6'd0, ADDR_ONES, 16'hFFFF, 16'hFFFF));
    send_item(make_item(OP_FIND_ALL, 6'd0, ADDR_ONES, 16'h1234, 16'h0));
    send_item(make_item(OP_EXISTS, 6'd0, ADDR_ONES, 16'h0, 16'h0));
    send_item(make_item(OP_EXISTS, 6'd63, 48'h0, 16'h1234, 16'hABCD));
    send_item(make_item(OP_SPARE_A, 6'd0, ADDR_ONES, 16'hFFFF, 16'hFFFF));
    send_item(make_item(OP_SPARE_B, 6'd63, 48'h0, 16'h0, 16'h0));
    send_item(make_item(OP_REMOVE, 6'd0, 48'h0, 16'h0, 16'h0));
    send_item(make_item(OP_FIND_ADDR, 6'd0, ADDR_ONES, 16'h0, 16'h0));
    send_item(make_item(OP_REMOVE, 6'd0, 48'h0, 16'h0, 16'h0));
    drain();

    // With one slot in use, slot 63 keeps its contents but is out of reach.
    set_active(7'd1);
    send_item(make_item(OP_ADD, 6'd1, ADDR_MIX, 16'h5, 16'h6));
    send_item(make_item(OP_REMOVE, 6'd63, 48'h0, 16'h0, 16'h0));
    send_item(make_item(OP_EXISTS, 6'd0, 48'h0, 16'h0, 16'h0));
    send_item(make_item(OP_ADD, 6'd0, ADDR_MIX, 16'h5, 16'h6));
    send_item(make_item(OP_FIND_ALL, 6'd0, ADDR_MIX, 16'h5, 16'h6));
    drain();

    set_active(7'd0);
    send_item(make_item(OP_ADD, 6'd0, ADDR_MIX, 16'h5, 16'h6));
    send_item(make_item(OP_FIND_ADDR, 6'd0, ADDR_MIX, 16'h0, 16'h0));
    drain();

    set_active(7'd127);
    send_item(make_item(OP_EXISTS, 6'd0, 48'h0, 16'h0, 16'h0));
    send_item(make_item(OP_REMOVE, 6'd63, 48'h0, 16'h0, 16'h0));
    send_item(make_item(OP_EXISTS, 6'd0, 48'h0, 16'h0, 16'h0));

    for (p = 0; p < NUM_PHASES; p++) begin
      drain();
      set_active(7'(phase_active[p]));
      send_idle_pct = phase_idle[p];
      stall_pct = phase_stall[p];
      if (p == 0) -> hold_go;
      for (k = 0; k < PHASE_ITEMS; k++) begin
        send_item(random_item());
        while ($urandom_range(99) < send_idle_pct) begin
          in_valid <= 1'b0;
          @(posedge clk);
        end
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.lookup_results.size() == 0)
      $display("client_connection_match_table: match");
    else
      $display("client_connection_match_table: mismatch");
    $finish;
  end

endmodule
